@@ rtl/amscr_pkg.sv @@
package amscr_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int CHANNEL_SLOTS = 8;
    localparam int MASK_W        = 8;
    localparam int VOL_W         = 15;
    localparam int LEVEL_W       = 15;
    localparam int UNITY_GAIN    = 16384;
    localparam int GAIN_SHIFT    = 14;
    localparam int FULL_POS      = 32767;
    localparam int FULL_NEG      = -32768;

    // Sum of up to eight channels, then the scaled and floored mix value.
    localparam int SUM_W         = 19;
    localparam int MIX_W         = 20;
    // Soft-clip divisor and quotient.
    localparam int DIV_W         = 18;
    localparam int QUO_W         = 15;
    // Square of one output sample.
    localparam int SQ_W          = 31;
    // Level search: (L*32767) is 30 bits, its square is split in two halves.
    localparam int LS_W          = 30;

    localparam int IN_DATA_W     = SAMPLE_W * CHANNEL_SLOTS;
    localparam int OUT_DATA_W    = 32;
    localparam int APB_DATA_W    = 32;
    localparam int PADDR_W       = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam int DEFAULT_CHANNELS = 8;
    localparam int DEFAULT_WINDOW   = 1024;

    // Register index, taken from byte address bit 2.
    localparam logic REG_VOLUME  = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLIP,
        ST_SQUARE,
        ST_ACCUM,
        ST_LV_SQ,
        ST_LV_LO,
        ST_LV_HI,
        ST_LV_CMP,
        ST_OUT
    } back_state_t;

endpackage

@@ rtl/amscr_front.sv @@
module amscr_front #(
    parameter int CHANNELS = amscr_pkg::DEFAULT_CHANNELS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [amscr_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic [amscr_pkg::MASK_W-1:0]           s_tuser,
    input  logic [amscr_pkg::VOL_W-1:0]            volume,
    output logic                                   q_valid,
    input  logic                                   q_ready,
    output logic [amscr_pkg::MIX_W-1:0]            q_data
);
    import amscr_pkg::*;

    localparam int PROD_W = SUM_W + VOL_W + 1;

    logic                     busy_reg;
    logic                     busy_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [PROD_W-1:0] prod;
    logic                     s_accept;

    assign s_tready = !busy_reg || q_ready;
    assign s_accept = s_tvalid && s_tready;

    // Sum the active channels; mask bits beyond CHANNELS are dropped.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < CHANNEL_SLOTS; i++)
        begin
            if (i < CHANNELS && s_tuser[i])
            begin
                sum_next = sum_next
                         + SUM_W'(signed'(s_tdata[i*SAMPLE_W +: SAMPLE_W]));
            end
        end
    end

    // Floor shift by GAIN_SHIFT is a plain bit select of the signed product.
    assign prod    = sum_reg * $signed({1'b0, volume});
    assign q_data  = prod[GAIN_SHIFT +: MIX_W];
    assign q_valid = busy_reg;

    assign busy_next = s_accept || (busy_reg && !q_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

@@ rtl/amscr_fifo.sv @@
module amscr_fifo #(
    parameter int WIDTH = amscr_pkg::MIX_W,
    parameter int DEPTH = amscr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/amscr_back.sv @@
module amscr_back #(
    parameter int WINDOW_SAMPLES = amscr_pkg::DEFAULT_WINDOW
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [amscr_pkg::MIX_W-1:0]         q_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [amscr_pkg::SAMPLE_W-1:0]      m_sample,
    output logic [amscr_pkg::LEVEL_W-1:0]       m_level,
    output logic                                m_updated
);
    import amscr_pkg::*;

    localparam int WW     = $clog2(WINDOW_SAMPLES + 1);
    localparam int ACC_W  = SQ_W + $clog2(WINDOW_SAMPLES);
    localparam int PP_W   = LS_W + WW;
    localparam int CMP_W  = 2 * LS_W + WW;
    localparam logic [WW-1:0] WIN      = WW'(WINDOW_SAMPLES);
    localparam logic [WW-1:0] WIN_LAST = WW'(WINDOW_SAMPLES - 1);
    localparam logic signed [MIX_W-1:0]    MIX_POS = MIX_W'(FULL_POS);
    localparam logic signed [MIX_W-1:0]    MIX_NEG = MIX_W'(FULL_NEG);
    localparam logic [QUO_W-1:0]           NUMER   = QUO_W'(FULL_POS);
    localparam logic [SAMPLE_W-1:0]        S_POS   = SAMPLE_W'(FULL_POS);
    localparam logic [SAMPLE_W-1:0]        S_NEG   = SAMPLE_W'(FULL_NEG);
    localparam logic [LEVEL_W-1:0]         UNITY   = LEVEL_W'(UNITY_GAIN);
    localparam logic [3:0]                 TOP_BIT = 4'(LEVEL_W - 1);

    back_state_t                state_reg, state_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [DIV_W-1:0]           divisor_reg, divisor_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next;
    logic                       neg_reg, neg_next;
    logic [3:0]                 step_reg, step_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [WW-1:0]              count_reg, count_next;
    logic [LEVEL_W-1:0]         level_reg, level_next;
    logic [LEVEL_W-1:0]         lv_reg, lv_next;
    logic [2*LS_W-1:0]          lsq_reg, lsq_next;
    logic [PP_W-1:0]            plo_reg, plo_next;
    logic [PP_W-1:0]            phi_reg, phi_next;
    logic                       updated_reg, updated_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_sample_reg, out_sample_next;
    logic [LEVEL_W-1:0]         out_level_reg, out_level_next;
    logic                       out_updated_reg, out_updated_next;

    logic signed [MIX_W-1:0]      mix;
    logic [DIV_W:0]               trial;
    logic                         trial_ge;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [LEVEL_W-1:0]           cand;
    logic [LS_W-1:0]              scaled;
    logic [CMP_W-1:0]             lhs;
    logic [CMP_W-1:0]             rhs;
    logic                         lv_done;

    assign mix      = q_data;
    assign trial    = {rem_reg, NUMER[step_reg]};
    assign trial_ge = trial >= {1'b0, divisor_reg};
    assign sq_full  = sample_reg * sample_reg;
    assign cand     = lv_reg | (LEVEL_W'(1) << step_reg);
    assign scaled   = {LS_W'(cand) << 15} - LS_W'(cand);
    assign lhs      = (CMP_W'(phi_reg) << LS_W) + CMP_W'(plo_reg);
    assign rhs      = CMP_W'(acc_reg) << 28;
    assign lv_done  = step_reg == '0;

    assign q_ready   = state_reg == ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_sample  = out_sample_reg;
    assign m_level   = out_level_reg;
    assign m_updated = out_updated_reg;

    always_comb
    begin
        state_next       = state_reg;
        sample_next      = sample_reg;
        divisor_next     = divisor_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        neg_next         = neg_reg;
        step_next        = step_reg;
        sq_next          = sq_reg;
        acc_next         = acc_reg;
        count_next       = count_reg;
        level_next       = level_reg;
        lv_next          = lv_reg;
        lsq_next         = lsq_reg;
        plo_next         = plo_reg;
        phi_next         = phi_reg;
        updated_next     = updated_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_sample_next  = out_sample_reg;
        out_level_next   = out_level_reg;
        out_updated_next = out_updated_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    rem_next  = '0;
                    quo_next  = '0;
                    step_next = 4'(QUO_W - 1);
                    if (mix > MIX_POS)
                    begin
                        neg_next     = 1'b0;
                        divisor_next = DIV_W'(mix - MIX_POS + MIX_W'(1));
                        state_next   = ST_DIV;
                    end
                    else if (mix < MIX_NEG)
                    begin
                        neg_next     = 1'b1;
                        divisor_next = DIV_W'(MIX_NEG + MIX_W'(1) - mix);
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        sample_next = SAMPLE_W'(mix);
                        state_next  = ST_SQUARE;
                    end
                end
            end
            ST_DIV:
            begin
                // Restoring division of 32767 by the overshoot plus one, one bit a cycle.
                rem_next = trial_ge ? DIV_W'(trial - {1'b0, divisor_reg}) : DIV_W'(trial);
                quo_next = {quo_reg[QUO_W-2:0], trial_ge};
                if (step_reg == '0)
                begin
                    state_next = ST_CLIP;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_CLIP:
            begin
                sample_next = neg_reg ? S_NEG + SAMPLE_W'(quo_reg)
                                      : S_POS - SAMPLE_W'(quo_reg);
                state_next  = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                sq_next    = SQ_W'(sq_full);
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                acc_next = acc_reg + ACC_W'(sq_reg);
                if (count_reg == WIN_LAST)
                begin
                    count_next   = '0;
                    lv_next      = '0;
                    step_next    = TOP_BIT;
                    updated_next = 1'b1;
                    state_next   = ST_LV_SQ;
                end
                else
                begin
                    count_next   = count_reg + 1'b1;
                    updated_next = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_LV_SQ:
            begin
                if (cand > UNITY)
                begin
                    // Candidate above full scale: skip this bit.
                    if (lv_done)
                    begin
                        level_next = lv_reg;
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        step_next = step_reg - 1'b1;
                    end
                end
                else
                begin
                    lsq_next   = scaled * scaled;
                    state_next = ST_LV_LO;
                end
            end
            ST_LV_LO:
            begin
                plo_next   = lsq_reg[LS_W-1:0] * WIN;
                state_next = ST_LV_HI;
            end
            ST_LV_HI:
            begin
                phi_next   = lsq_reg[2*LS_W-1:LS_W] * WIN;
                state_next = ST_LV_CMP;
            end
            ST_LV_CMP:
            begin
                if (lhs <= rhs)
                begin
                    lv_next = cand;
                end
                if (lv_done)
                begin
                    level_next = (lhs <= rhs) ? cand : lv_reg;
                    acc_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next  = step_reg - 1'b1;
                    state_next = ST_LV_SQ;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_sample_next  = sample_reg;
                    out_level_next   = level_reg;
                    out_updated_next = updated_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        divisor_reg     <= divisor_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        neg_reg         <= neg_next;
        step_reg        <= step_next;
        sq_reg          <= sq_next;
        lv_reg          <= lv_next;
        lsq_reg         <= lsq_next;
        plo_reg         <= plo_next;
        phi_reg         <= phi_next;
        updated_reg     <= updated_next;
        out_sample_reg  <= out_sample_next;
        out_level_reg   <= out_level_next;
        out_updated_reg <= out_updated_next;
    end

endmodule

@@ rtl/audio_mixer_soft_clip_rms.sv @@
// An in-range sample passes the front-end register, the queue and the back-end
// square, accumulate and output states to m_tvalid; a clipped sample first
// runs the soft-clip divider, and a sample that closes a window adds the level
// search (15 bits, 4 steps each). New frames queue while the back end is busy.
// Reset (rst_n, async, active low): volume to unity, accumulator, window count
// and level to zero, queue and output register empty.
module audio_mixer_soft_clip_rms #(
    parameter int CHANNELS       = amscr_pkg::DEFAULT_CHANNELS,
    parameter int WINDOW_SAMPLES = amscr_pkg::DEFAULT_WINDOW
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel_sample_0 .. channel_sample_7, 16 bits each
    input  logic [amscr_pkg::IN_DATA_W-1:0]     s_tdata,
    // active_mask
    input  logic [amscr_pkg::MASK_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mixed_sample [15:0], output_level [30:16], zero [31]
    output logic [amscr_pkg::OUT_DATA_W-1:0]    m_tdata,
    // level_updated
    output logic                                m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [amscr_pkg::PADDR_W-1:0]       paddr,
    input  logic [amscr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amscr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import amscr_pkg::*;

    logic [VOL_W-1:0]    volume_reg;
    logic [VOL_W-1:0]    volume_next;
    logic [VOL_W-1:0]    wr_value;
    logic                vol_write;
    logic                q_in_valid;
    logic                q_in_ready;
    logic [MIX_W-1:0]    q_in_data;
    logic                q_out_valid;
    logic                q_out_ready;
    logic [MIX_W-1:0]    q_out_data;
    logic [SAMPLE_W-1:0] out_sample;
    logic [LEVEL_W-1:0]  out_level;

    assign pready    = 1'b1;
    assign vol_write = psel && penable && pwrite && pready && (paddr[2] == REG_VOLUME);
    assign wr_value  = pwdata[VOL_W-1:0];
    // Saturate writes above unity.
    assign volume_next = (wr_value > VOL_W'(UNITY_GAIN)) ? VOL_W'(UNITY_GAIN) : wr_value;
    assign prdata    = (paddr[2] == REG_VOLUME) ? APB_DATA_W'(volume_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= VOL_W'(UNITY_GAIN);
        end
        else if (vol_write)
        begin
            volume_reg <= volume_next;
        end
    end

    amscr_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .volume   (volume_reg),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_data   (q_in_data)
    );

    amscr_fifo #(
        .WIDTH (MIX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    amscr_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_data    (q_out_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_sample  (out_sample),
        .m_level   (out_level),
        .m_updated (m_tuser)
    );

    assign m_tdata = {1'b0, out_level, out_sample};

endmodule
